### rtl/ppvp_pkg.sv
`timescale 1ns / 1ps
package ppvp_pkg;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 48;

	localparam logic [CfgIdxW-1:0] REG_NORMAL  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_EYE_X   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_EYE_Y   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_EYE_Z   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PLANE   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BASIS_U = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_BASIS_V = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN  = 3'd7;

	// Divider: |num*2^16| <= 2^47, |down| < 2^23 -> quotient fits 48 bits magnitude.
	localparam int NumW = 48;
	localparam int DenW = 23;

	// x sits in the low byte, z in the high byte
	typedef struct packed {
		logic signed [7:0] z;
		logic signed [7:0] y;
		logic signed [7:0] x;
	} normal_t;

	typedef struct packed {
		normal_t            n;
		logic signed [12:0] ex;
		logic signed [12:0] ey;
		logic signed [12:0] ez;
		logic signed [31:0] pnum;
		logic [47:0]        wu;
		logic [47:0]        wv;
		logic [47:0]        org;
	} cfg_t;
endpackage

### rtl/ppvp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module ppvp_div import ppvp_pkg::*; #(
	parameter int TagW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [NumW-1:0]    in_num,
	input  logic [DenW-1:0]    in_den,
	input  logic [TagW-1:0]    in_tag,
	output logic               out_valid,
	output logic [NumW-1:0]    out_quo,
	output logic [TagW-1:0]    out_tag
);
	logic            v_s  [NumW+1];
	logic [NumW-1:0] q_s  [NumW+1];
	logic [DenW:0]   r_s  [NumW+1];
	logic [DenW-1:0] d_s  [NumW+1];
	logic [TagW-1:0] t_s  [NumW+1];

	assign v_s[0] = in_valid;
	assign q_s[0] = in_num;
	assign r_s[0] = '0;
	assign d_s[0] = in_den;
	assign t_s[0] = in_tag;

	for (genvar k = 0; k < NumW; k++) begin : g_st
		logic [DenW+1:0] sh;
		logic [DenW+1:0] df;
		assign sh = {r_s[k], q_s[k][NumW-1]};
		assign df = sh - {2'b0, d_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= d_s[k];
				t_s[k+1] <= t_s[k];
				if (!df[DenW+1]) begin
					r_s[k+1] <= df[DenW:0];
					q_s[k+1] <= {q_s[k][NumW-2:0], 1'b1};
				end else begin
					r_s[k+1] <= sh[DenW:0];
					q_s[k+1] <= {q_s[k][NumW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[NumW];
	assign out_quo   = q_s[NumW];
	assign out_tag   = t_s[NumW];
endmodule

### rtl/project_point_to_view_plane.sv
`timescale 1ns / 1ps
// Perspective projection of a 3D point onto a configured view plane.
// Input channel: in_valid/in_stall with point_x/y/z, one transaction per point.
// Output channel: out_valid/out_stall with screen_u/v, on_screen, degenerate.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// only while the pipeline is empty. Unknown indices are ignored.
// Pipeline from input transaction to result valid:
//   s1 ray direction, s2 products with normal, s3 dot-product sum (denominator),
//   48 divider stages (one quotient bit each), then t saturate, t*d products,
//   basis products, sums, and output format stages.
// Throughput: one point per cycle. The whole pipeline advances as one when
// the output register is free or taken; in_stall = out_valid & out_stall, so a
// stalled result holds and nothing is lost or repeated.
// Reset: all valid bits clear; registers return to normal (1,1,2), eye
// (500,600,500), plane_num -600, zero basis, origin (357,429,357).
// Degenerate rays (zero denominator) flag degenerate and give zero coords.
module project_point_to_view_plane import ppvp_pkg::*; #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 600
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [11:0]   point_x,
	input  logic signed [11:0]   point_y,
	input  logic signed [11:0]   point_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   screen_u,
	output logic signed [15:0]   screen_v,
	output logic                 on_screen,
	output logic                 degenerate,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);
	localparam logic signed [63:0] OffU = 64'(SCREEN_WIDTH / 2) <<< 30;
	localparam logic signed [63:0] OffV = 64'(SCREEN_HEIGHT / 2) <<< 30;
	localparam logic signed [63:0] LimU = 64'(SCREEN_WIDTH) <<< 30;
	localparam logic signed [63:0] LimV = 64'(SCREEN_HEIGHT) <<< 30;

	cfg_t cfg_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n    <= normal_t'(24'h020101);
			cfg_q.ex   <= 13'sd500;
			cfg_q.ey   <= 13'sd600;
			cfg_q.ez   <= 13'sd500;
			cfg_q.pnum <= -32'sd600;
			cfg_q.wu   <= '0;
			cfg_q.wv   <= '0;
			cfg_q.org  <= 48'd1533331439973;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NORMAL:  cfg_q.n    <= normal_t'(cfg_data[23:0]);
				REG_EYE_X:   cfg_q.ex   <= cfg_data[12:0];
				REG_EYE_Y:   cfg_q.ey   <= cfg_data[12:0];
				REG_EYE_Z:   cfg_q.ez   <= cfg_data[12:0];
				REG_PLANE:   cfg_q.pnum <= cfg_data[31:0];
				REG_BASIS_U: cfg_q.wu   <= cfg_data;
				REG_BASIS_V: cfg_q.wv   <= cfg_data;
				REG_ORIGIN:  cfg_q.org  <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: direction d = P - E (14 bits)
	logic v_s1;
	logic signed [13:0] dx_s1, dy_s1, dz_s1;
	// s2: products with normal
	logic v_s2;
	logic signed [13:0] dx_s2, dy_s2, dz_s2;
	logic signed [21:0] px_s2, py_s2, pz_s2;
	// s3: down; the numerator is formed combinationally from the plane register
	logic v_s3;
	logic signed [23:0] down_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	logic signed [13:0] dx_s3, dy_s3, dz_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 14'(point_x) - 14'(cfg_q.ex);
			dy_s1 <= 14'(point_y) - 14'(cfg_q.ey);
			dz_s1 <= 14'(point_z) - 14'(cfg_q.ez);
			dx_s2 <= dx_s1; dy_s2 <= dy_s1; dz_s2 <= dz_s1;
			px_s2 <= 22'(dx_s1 * cfg_q.n.x);
			py_s2 <= 22'(dy_s1 * cfg_q.n.y);
			pz_s2 <= 22'(dz_s1 * cfg_q.n.z);
			dx_s3 <= dx_s2; dy_s3 <= dy_s2; dz_s3 <= dz_s2;
			down_s3 <= 24'(px_s2) + 24'(py_s2) + 24'(pz_s2);
		end
	end

	// divider on magnitudes, sign travels in the tag
	logic signed [47:0] num_w;
	logic [NumW-1:0] num_mag;
	logic [DenW-1:0] den_mag;
	logic [23:0] down_abs;
	logic neg_w, zero_w;
	assign num_w    = 48'(cfg_q.pnum) <<< 16;
	assign num_mag  = num_w[47] ? NumW'(-num_w) : NumW'(num_w);
	assign down_abs = down_s3[23] ? 24'(-down_s3) : 24'(down_s3);
	assign den_mag  = zero_w ? DenW'(1) : down_abs[DenW-1:0];
	assign neg_w    = num_w[47] ^ down_s3[23];
	assign zero_w   = (down_s3 == '0);

	localparam int TagW = 44;
	logic dv_w;
	logic [NumW-1:0] quo_w;
	logic [TagW-1:0] tag_w;
	ppvp_div #(.TagW(TagW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .in_num(num_mag), .in_den(den_mag),
		.in_tag({neg_w, zero_w, dx_s3, dy_s3, dz_s3}),
		.out_valid(dv_w), .out_quo(quo_w), .out_tag(tag_w)
	);

	// s4: sign-apply + saturate t
	logic v_s4, z_s4;
	logic signed [31:0] t_s4;
	logic signed [13:0] dx_s4, dy_s4, dz_s4;
	logic signed [48:0] ts_w;
	assign ts_w = tag_w[43] ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});

	// s5: t*d products plus (E - p0)*2^16
	logic v_s5, z_s5;
	logic signed [46:0] rx_s5, ry_s5, rz_s5;
	logic signed [46:0] td_x, td_y, td_z;
	assign td_x = 47'(t_s4 * dx_s4);
	assign td_y = 47'(t_s4 * dy_s4);
	assign td_z = 47'(t_s4 * dz_s4);
	logic signed [17:0] ox_w, oy_w, oz_w;
	assign ox_w = 18'(cfg_q.ex) - 18'($signed(cfg_q.org[15:0]));
	assign oy_w = 18'(cfg_q.ey) - 18'($signed(cfg_q.org[31:16]));
	assign oz_w = 18'(cfg_q.ez) - 18'($signed(cfg_q.org[47:32]));

	// s6: basis products (47 x 16 split into high and low parts)
	logic v_s6, z_s6;
	logic signed [63:0] uhx_s6, uhy_s6, uhz_s6, vhx_s6, vhy_s6, vhz_s6;
	logic signed [63:0] ulx_s6, uly_s6, ulz_s6, vlx_s6, vly_s6, vlz_s6;

	function automatic logic signed [63:0] mhi(input logic signed [46:0] r,
	                                           input logic signed [15:0] w);
		logic signed [30:0] hi;
		begin
			hi = r[46:16];
			mhi = 64'(hi * w) <<< 16;
		end
	endfunction
	function automatic logic signed [63:0] mlo(input logic signed [46:0] r,
	                                           input logic signed [15:0] w);
		logic signed [16:0] lo;
		begin
			lo = $signed({1'b0, r[15:0]});
			mlo = 64'(lo * w);
		end
	endfunction

	// s7: sums
	logic v_s7, z_s7;
	logic signed [63:0] su_s7, sv_s7;
	// s8: format
	logic signed [63:0] qu_w, qv_w;
	logic signed [15:0] u_w, v_w;
	assign qu_w = su_s7[63] ? -((-su_s7) >>> 30) : (su_s7 >>> 30);
	assign qv_w = sv_s7[63] ? -((-sv_s7) >>> 30) : (sv_s7 >>> 30);

	function automatic logic signed [15:0] sat16(input logic signed [63:0] q);
		begin
			if (q > 64'sd32767) sat16 = 16'sh7fff;
			else if (q < -64'sd32768) sat16 = -16'sh8000;
			else sat16 = q[15:0];
		end
	endfunction
	assign u_w = sat16(qu_w);
	assign v_w = sat16(qv_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s4 <= dv_w; v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			out_valid <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s4 <= tag_w[42];
			dx_s4 <= tag_w[41:28]; dy_s4 <= tag_w[27:14]; dz_s4 <= tag_w[13:0];
			if (ts_w > 49'sh7fffffff) t_s4 <= 32'sh7fffffff;
			else if (ts_w < -49'sh80000000) t_s4 <= -32'sh80000000;
			else t_s4 <= ts_w[31:0];

			z_s5 <= z_s4;
			rx_s5 <= (47'(ox_w) <<< 16) + td_x;
			ry_s5 <= (47'(oy_w) <<< 16) + td_y;
			rz_s5 <= (47'(oz_w) <<< 16) + td_z;

			z_s6 <= z_s5;
			uhx_s6 <= mhi(rx_s5, cfg_q.wu[15:0]);  ulx_s6 <= mlo(rx_s5, cfg_q.wu[15:0]);
			uhy_s6 <= mhi(ry_s5, cfg_q.wu[31:16]); uly_s6 <= mlo(ry_s5, cfg_q.wu[31:16]);
			uhz_s6 <= mhi(rz_s5, cfg_q.wu[47:32]); ulz_s6 <= mlo(rz_s5, cfg_q.wu[47:32]);
			vhx_s6 <= mhi(rx_s5, cfg_q.wv[15:0]);  vlx_s6 <= mlo(rx_s5, cfg_q.wv[15:0]);
			vhy_s6 <= mhi(ry_s5, cfg_q.wv[31:16]); vly_s6 <= mlo(ry_s5, cfg_q.wv[31:16]);
			vhz_s6 <= mhi(rz_s5, cfg_q.wv[47:32]); vlz_s6 <= mlo(rz_s5, cfg_q.wv[47:32]);

			z_s7 <= z_s6;
			su_s7 <= uhx_s6 + ulx_s6 + uhy_s6 + uly_s6 + uhz_s6 + ulz_s6 + OffU;
			sv_s7 <= vhx_s6 + vlx_s6 + vhy_s6 + vly_s6 + vhz_s6 + vlz_s6 + OffV;

			degenerate <= z_s7;
			screen_u   <= z_s7 ? '0 : u_w;
			screen_v   <= z_s7 ? '0 : v_w;
			on_screen  <= !z_s7 && su_s7 > 0 && su_s7 < LimU && sv_s7 > 0 && sv_s7 < LimV;
		end
	end
endmodule

### rtl/ppvp_checker.sv
`timescale 1ns / 1ps
module ppvp_checker import ppvp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] screen_u,
	input logic signed [15:0] screen_v,
	input logic               on_screen,
	input logic               degenerate
);
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> screen_u == 0 && screen_v == 0 && !on_screen)
		else $error("degenerate result carries coordinates");
	a_onscreen_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_screen |-> screen_u >= 0 && screen_v >= 0)
		else $error("on_screen with negative coordinate");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_u) && $stable(screen_v))
		else $error("stalled result changed");
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
endmodule

bind project_point_to_view_plane ppvp_checker u_ppvp_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .screen_u(screen_u),
	.screen_v(screen_v), .on_screen(on_screen), .degenerate(degenerate)
);
